>>> rtl/core/sfsp_pkg.sv
// shared types, constants and helper functions for the station frame signal parser
`default_nettype none

package sfsp_pkg;

   localparam int unsigned MaxFrameDefault = 256;
   localparam int unsigned HeadDepth       = 4;
   localparam int unsigned HeadCountW      = 3;
   localparam int unsigned StationW        = 7;
   localparam logic [7:0]  CrByte          = 8'h0d;

   typedef logic [7:0] char_type;

   typedef struct packed {
      logic [HeadCountW-1:0] head_count;
      char_type [HeadDepth-1:0] head_chars;
   } frame_view_type;

   typedef struct packed {
      logic       frame_end;
      logic [7:0] signal_code;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   function automatic hex_digit_type hex_value(input char_type ch);
      hex_digit_type result;
      char_type      diff;
      result = '{valid: 1'b0, nibble: 4'd0};
      diff   = 8'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         diff   = ch - 8'h30;
         result = '{valid: 1'b1, nibble: diff[3:0]};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         diff   = ch - 8'h57;
         result = '{valid: 1'b1, nibble: diff[3:0]};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         diff   = ch - 8'h37;
         result = '{valid: 1'b1, nibble: diff[3:0]};
      end
      return result;
   endfunction

   // two ascii decimal digits of the station number modulo 100, tens first
   function automatic logic [15:0] station_digits(input logic [StationW-1:0] station);
      logic [StationW-1:0] st;
      logic [14:0]         prod;
      logic [3:0]          tens;
      logic [StationW-1:0] tens_x10;
      logic [StationW-1:0] ones;
      st       = (station >= StationW'(100)) ? station - StationW'(100) : station;
      prod     = 15'(st) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = StationW'(tens) * StationW'(10);
      ones     = st - tens_x10;
      return {8'h30 + 8'(tens), 8'h30 + 8'(ones)};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfsp_frame.sv
// frame collector: byte count and capture of the first frame characters
`default_nettype none

module sfsp_frame #(
   parameter int unsigned MAX_FRAME = sfsp_pkg::MaxFrameDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire sfsp_pkg::char_type      rx_byte,
   output sfsp_pkg::frame_view_type     view
);

   localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
   localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME);
   localparam logic [CntW-1:0] HeadLimit = CntW'(sfsp_pkg::HeadDepth);

   logic [CntW-1:0]    count_ff, count_in;
   sfsp_pkg::char_type [sfsp_pkg::HeadDepth-1:0] head_ff;
   logic               head_we;

   always_comb begin
      count_in = count_ff;
      head_we  = 1'b0;
      if (accept) begin
         if (rx_byte == sfsp_pkg::CrByte) begin
            count_in = '0;
         end else if (count_ff == MaxCnt) begin
            count_in = '0;
         end else begin
            head_we  = (count_ff < HeadLimit);
            count_in = count_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[count_ff[1:0]] <= rx_byte;
      end
   end

   assign view.head_count = (count_ff < HeadLimit) ? count_ff[sfsp_pkg::HeadCountW-1:0]
                                                   : sfsp_pkg::HeadCountW'(sfsp_pkg::HeadDepth);
   assign view.head_chars = head_ff;

endmodule

`default_nettype wire

>>> rtl/core/sfsp_decode.sv
// station match and hex signal decode at frame end
`default_nettype none

module sfsp_decode (
   input  wire logic [sfsp_pkg::StationW-1:0] station,
   input  wire sfsp_pkg::frame_view_type      view,
   input  wire sfsp_pkg::char_type            rx_byte,
   output sfsp_pkg::result_type               result
);

   logic [15:0]             digits;
   logic                    station_match;
   sfsp_pkg::hex_digit_type hi_digit;
   sfsp_pkg::hex_digit_type lo_digit;
   logic [7:0]              code;

   always_comb begin
      digits        = sfsp_pkg::station_digits(station);
      station_match = (view.head_count >= sfsp_pkg::HeadCountW'(2))
                      && (view.head_chars[0] == digits[15:8])
                      && (view.head_chars[1] == digits[7:0]);
      hi_digit      = sfsp_pkg::hex_value(view.head_chars[2]);
      lo_digit      = sfsp_pkg::hex_value(view.head_chars[3]);
      code          = 8'd0;
      if (station_match && view.head_count >= sfsp_pkg::HeadCountW'(3) && hi_digit.valid) begin
         if (view.head_count >= sfsp_pkg::HeadCountW'(4) && lo_digit.valid) begin
            code = {hi_digit.nibble, lo_digit.nibble};
         end else begin
            code = {4'd0, hi_digit.nibble};
         end
      end
      result.frame_end   = (rx_byte == sfsp_pkg::CrByte);
      result.signal_code = result.frame_end ? code : 8'd0;
   end

endmodule

`default_nettype wire

>>> rtl/core/sfsp_out_buf.sv
// result register with skid stage
`default_nettype none

module sfsp_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire sfsp_pkg::result_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output sfsp_pkg::result_type      out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   sfsp_pkg::result_type out_ff, out_in;
   sfsp_pkg::result_type skid_ff, skid_in;
   logic                 in_accept;
   logic                 out_free;

   assign in_accept = in_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (in_accept) begin
            out_in       = in_data;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_accept) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

>>> rtl/core/station_frame_signal_parser_unit.sv
// top level of the station frame signal parser
//
// Takes one received byte per transaction and returns one result per byte, one byte per
// cycle sustained; the rate is set by the result register and its skid stage, which
// stall the input only when both are full.
// A carriage return closes the frame: if the first two characters are the station
// number (modulo 100) as two decimal digits, the signal code is decoded from one or two
// hex digits at positions 2 and 3, else it is 0. A frame longer than MAX_FRAME bytes
// drops the byte and restarts the count. Write the station register only while idle.
`default_nettype none

module station_frame_signal_parser_unit #(
   parameter int unsigned MAX_FRAME = sfsp_pkg::MaxFrameDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_frame_end,
   output logic [7:0]                         rsp_signal_code,
   input  wire logic                          csr_wr_en,
   input  wire logic [sfsp_pkg::StationW-1:0] csr_wr_data
);

   logic [sfsp_pkg::StationW-1:0] station_ff;
   logic                          req_accept;
   sfsp_pkg::frame_view_type      view;
   sfsp_pkg::result_type          result;
   sfsp_pkg::result_type          rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= '0;
      end else if (csr_wr_en) begin
         station_ff <= csr_wr_data;
      end
   end

   assign req_accept = req_valid && !req_stall;

   sfsp_frame #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .view    (view)
   );

   sfsp_decode u_decode (
      .station (station_ff),
      .view    (view),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   sfsp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_frame_end   = rsp_data.frame_end;
   assign rsp_signal_code = rsp_data.signal_code;

   // skid stage holds a transaction only behind a full result register
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("skid stage full with empty result register");

   // every accepted byte leaves a valid result in the next cycle, though it may be an earlier one held by a stall
   assert property (@(posedge clock) disable iff (reset) req_accept |=> rsp_valid)
      else $error("accepted byte gave no result");

   // a code is only reported on a frame end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_end) |-> (rsp_signal_code == 8'd0))
      else $error("signal code outside frame end");

endmodule

`default_nettype wire

>>> test/tb_station_frame_signal_parser_unit.sv
// self-checking testbench for the station frame signal parser with a frame scoreboard

class frame_scoreboard;
   localparam int unsigned FrameLimit = sfsp_pkg::MaxFrameDefault;

   logic [sfsp_pkg::StationW-1:0] station;
   int unsigned                   fill;
   logic [7:0]                    head [sfsp_pkg::HeadDepth];
   sfsp_pkg::result_type          codes_due [$];
   int unsigned                   errors;
   int unsigned                   frames;
   int unsigned                   hits;

   function new();
      station = '0;
      fill    = 0;
      errors  = 0;
      frames  = 0;
      hits    = 0;
   endfunction

   // bit 4 set marks a character that is not a hex digit
   function logic [4:0] digit_value(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
      if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 10)};
      if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 10)};
      return 5'h10;
   endfunction

   function logic [7:0] signal_of_frame();
      logic [6:0] st;
      logic [7:0] tens;
      logic [7:0] ones;
      logic [4:0] hi;
      logic [4:0] lo;
      st   = station % 7'd100;
      tens = 8'h30 + 8'(st / 7'd10);
      ones = 8'h30 + 8'(st % 7'd10);
      if (fill < 2 || head[0] != tens || head[1] != ones || fill < 3) return 8'h00;
      hi = digit_value(head[2]);
      if (hi[4]) return 8'h00;
      if (fill < 4) return {4'h0, hi[3:0]};
      lo = digit_value(head[3]);
      if (lo[4]) return {4'h0, hi[3:0]};
      return {hi[3:0], lo[3:0]};
   endfunction

   function void accept_byte(logic [7:0] b);
      sfsp_pkg::result_type r;
      r = '0;
      if (b == sfsp_pkg::CrByte) begin
         r.frame_end   = 1'b1;
         r.signal_code = signal_of_frame();
         fill          = 0;
         frames++;
         if (r.signal_code != 8'h00) hits++;
      end else if (fill + 1 > FrameLimit) begin
         fill = 0;
      end else begin
         if (fill < sfsp_pkg::HeadDepth) head[fill] = b;
         fill++;
      end
      codes_due.push_back(r);
   endfunction

   function void check_result(logic fe, logic [7:0] sc);
      sfsp_pkg::result_type want;
      if (codes_due.size() == 0) begin
         $error("unexpected transaction: frame_end %0d signal_code %02h", fe, sc);
         errors++;
         return;
      end
      want = codes_due.pop_front();
      if (fe !== want.frame_end) begin
         $error("frame_end expected %0d actual %0d", want.frame_end, fe);
         errors++;
      end
      if (sc !== want.signal_code) begin
         $error("signal_code expected %02h actual %02h", want.signal_code, sc);
         errors++;
      end
   endfunction
endclass

module tb_station_frame_signal_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 200000;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_rx_byte     = 8'h00;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic                          rsp_frame_end;
   logic [7:0]                    rsp_signal_code;
   logic                          csr_wr_en       = 1'b0;
   logic [sfsp_pkg::StationW-1:0] csr_wr_data     = '0;

   frame_scoreboard board = new();
   int unsigned     cycles     = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     hold_left  = 0;
   int unsigned     settings   = 0;
   bit              calm       = 1'b0;

   station_frame_signal_parser_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_signal_code (rsp_signal_code),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (calm || k < 65) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic logic [7:0] any_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == sfsp_pkg::CrByte);
      return v;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: check each transaction and stall at random
   always @(posedge clock) begin
      int unsigned r;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_frame_end, rsp_signal_code);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else begin
            r = pick_gap();
            rsp_stall <= (r != 0);
            hold_left <= (r != 0) ? r - 1 : 0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      board.accept_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.codes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_station(input logic [sfsp_pkg::StationW-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.station = value;
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   task automatic send_frame(input string body);
      for (int i = 0; i < body.len(); i++) send_byte(body[i]);
      send_byte(sfsp_pkg::CrByte);
   endtask

   // fills the frame to its limit; with spill set one more byte is dropped and a new head follows
   task automatic send_long_frame(input bit spill);
      logic [6:0] st;
      st = board.station % 7'd100;
      send_byte(8'h30 + 8'(st / 7'd10));
      send_byte(8'h30 + 8'(st % 7'd10));
      send_byte("3");
      send_byte("C");
      repeat (sfsp_pkg::MaxFrameDefault - 4) send_byte(any_byte());
      if (spill) begin
         send_byte(any_byte());
         send_byte(8'h30 + 8'(st / 7'd10));
         send_byte(8'h30 + 8'(st % 7'd10));
         send_byte("e");
      end
      send_byte(sfsp_pkg::CrByte);
   endtask

   task automatic send_random_frame();
      logic [7:0] body [$];
      logic [6:0] st;
      int unsigned pick;
      string hex_set;
      string near_set;
      hex_set  = "0123456789abcdefABCDEF";
      near_set = "/:@G`g";
      st       = board.station % 7'd100;
      pick     = $urandom_range(0, 99);
      if (pick < 85) begin
         body.push_back(8'h30 + 8'(st / 7'd10));
         body.push_back(8'h30 + 8'(st % 7'd10));
         if (pick >= 70) body[$urandom_range(0, 1)] = 8'h30 + 8'($urandom_range(0, 9));
         repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) body.push_back(hex_set[$urandom_range(0, 21)]);
            else if (pick < 9) body.push_back(near_set[$urandom_range(0, 5)]);
            else body.push_back(any_byte());
         end
         repeat ($urandom_range(0, 5)) body.push_back(any_byte());
      end else begin
         repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
      end
      foreach (body[i]) send_byte(body[i]);
      send_byte(sfsp_pkg::CrByte);
   endtask

   initial begin
      logic [6:0]  plan [6];
      int unsigned phase_start;
      plan = '{7'd0, 7'd99, 7'd100, 7'd7, 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127))};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_station(7'd42);
      send_frame("");
      send_frame("4");
      send_frame("42");
      send_frame("42A");
      send_frame("42f7");
      send_frame("42G1");
      send_frame("42bx");

      // station above 99 compares as "27"
      load_station(7'd127);
      send_long_frame(1'b1);

      foreach (plan[p]) begin
         load_station(plan[p]);
         calm        = (p == 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 20) begin
            send_random_frame();
            if (p == 3 && bytes_sent - phase_start >= 10 && bytes_sent - phase_start < 14)
               wait_drained();
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (6) @(posedge clock);
      $display("%0d bytes over %0d station settings, including full and overflowing frames",
               bytes_sent, settings);
      $display("%0d frames closed, %0d with a decoded signal code", board.frames, board.hits);
      if (board.errors == 0 && board.codes_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/core/sfsp_pkg.sv
rtl/core/sfsp_frame.sv
rtl/core/sfsp_decode.sv
rtl/core/sfsp_out_buf.sv
rtl/core/station_frame_signal_parser_unit.sv
test/tb_station_frame_signal_parser_unit.sv
